// File: rtl/tmt_pkg.sv
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types, character codes and SGR codes of the text-mode terminal.
// ----------------------------------------------------------------------------
package tmt_pkg;

    // Command classes handed from the front end to the back end
    typedef enum logic [3:0] {
        OP_READ,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_ESC,
        OP_FF,
        OP_PRINT,
        OP_NOP,
        OP_SEQ_SKIP,
        OP_DIGIT,
        OP_SEMI,
        OP_SGR,
        OP_ABORT
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  code;
        logic [12:0] index;
        logic        seq;     // escape state after this item
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DFG  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DBG  = 2'd3;

    localparam logic [6:0] RST_ROWS = 7'd25;
    localparam logic [7:0] RST_COLS = 8'd80;
    localparam logic [3:0] RST_DFG  = 4'd7;
    localparam logic [3:0] RST_DBG  = 4'd0;

    localparam logic [15:0] RESET_CELL = 16'h0720;

    // Character codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_BLANK    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SGR_END  = 8'h6D;

    // SGR codes
    localparam logic [7:0] SGR_RESET  = 8'd0;
    localparam logic [7:0] SGR_BOLD   = 8'd1;
    localparam logic [7:0] SGR_FG_LO  = 8'd30;
    localparam logic [7:0] SGR_FG_HI  = 8'd37;
    localparam logic [7:0] SGR_FG_DEF = 8'd39;
    localparam logic [7:0] SGR_BG_LO  = 8'd40;
    localparam logic [7:0] SGR_BG_HI  = 8'd47;
    localparam logic [7:0] SGR_BG_DEF = 8'd49;

    localparam logic [3:0] BOLD_OFFSET = 4'd8;

    // ANSI colour number to VGA palette index
    function automatic logic [2:0] ansi_to_vga(input logic [2:0] a);
        logic [2:0] v;
        case (a)
            3'd0:    v = 3'd0;
            3'd1:    v = 3'd4;
            3'd2:    v = 3'd2;
            3'd3:    v = 3'd6;
            3'd4:    v = 3'd1;
            3'd5:    v = 3'd5;
            3'd6:    v = 3'd3;
            default: v = 3'd7;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/tmt_if.sv
// ----------------------------------------------------------------------------
// tmt_if
// Valid/ready channels of the text-mode terminal: request in, result out.
// ----------------------------------------------------------------------------
interface tmt_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  char_code;
    logic [12:0] cell_index;

    modport source (output valid, output req_type, output char_code,
                    output cell_index, input ready);
    modport sink   (input valid, input req_type, input char_code,
                    input cell_index, output ready);
endinterface

interface tmt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic        escape_active;

    modport source (output valid, output cell_value, output cursor_col,
                    output cursor_row, output escape_active, input ready);
    modport sink   (input valid, input cell_value, input cursor_col,
                    input cursor_row, input escape_active, output ready);
endinterface

// File: rtl/tmt_front.sv
// ----------------------------------------------------------------------------
// tmt_front
// Accepts requests, tracks the escape state and classifies each byte.
// ----------------------------------------------------------------------------
module tmt_front (
    input  logic          clk,
    input  logic          rst_n,
    tmt_in_if.sink        in_ch,
    input  logic          q_full,
    input  logic          init_busy,
    output logic          q_push,
    output tmt_pkg::cmd_t q_data
);
    import tmt_pkg::*;

    logic seq_reg;
    logic seq_next;

    assign in_ch.ready = !q_full && !init_busy;
    assign q_push      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        q_data.code  = in_ch.char_code;
        q_data.index = in_ch.cell_index;
        q_data.op    = OP_NOP;
        seq_next     = seq_reg;
        if (in_ch.req_type)
        begin
            q_data.op = OP_READ;
        end
        else if (seq_reg)
        begin
            unique case (in_ch.char_code) inside
                CH_LBRACKET:        q_data.op = OP_SEQ_SKIP;
                [CH_ZERO:CH_NINE]:  q_data.op = OP_DIGIT;
                CH_SEMI:            q_data.op = OP_SEMI;
                CH_SGR_END:
                begin
                    q_data.op = OP_SGR;
                    seq_next  = 1'b0;
                end
                default:
                begin
                    q_data.op = OP_ABORT;
                    seq_next  = 1'b0;
                end
            endcase
        end
        else
        begin
            unique case (in_ch.char_code) inside
                CH_BS:  q_data.op = OP_BS;
                CH_TAB: q_data.op = OP_TAB;
                CH_CR:  q_data.op = OP_CR;
                CH_LF:  q_data.op = OP_LF;
                CH_FF:  q_data.op = OP_FF;
                CH_ESC:
                begin
                    q_data.op = OP_ESC;
                    seq_next  = 1'b1;
                end
                [CH_BLANK:8'hFF]: q_data.op = OP_PRINT;
                default:          q_data.op = OP_NOP;
            endcase
        end
        q_data.seq = seq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seq_reg <= 1'b0;
        else if (q_push)
            seq_reg <= seq_next;
    end

endmodule

// File: rtl/tmt_queue.sv
// ----------------------------------------------------------------------------
// tmt_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module tmt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tmt_pkg::cmd_t push_data,
    input  logic          pop,
    output tmt_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    import tmt_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    assign full     = (32'(count_reg) == QUEUE_DEPTH);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : QAW'(p + 1'b1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = QCW'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = QCW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/tmt_back.sv
// ----------------------------------------------------------------------------
// tmt_back
// Executes commands: cursor, colours, SGR parser, screen store and scroll.
// ----------------------------------------------------------------------------
module tmt_back #(
    parameter int ROW_CAP    = 64,
    parameter int COL_CAP    = 128,
    parameter int MAX_PARAMS = 8,
    parameter int TAB_WIDTH  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          q_empty,
    input  tmt_pkg::cmd_t                 q_data,
    output logic                          q_pop,
    output logic                          init_busy,
    tmt_out_if.source                     out_ch
);
    import tmt_pkg::*;

    localparam int STORE_SIZE = ROW_CAP * COL_CAP;
    localparam int AW   = $clog2(STORE_SIZE);
    localparam int CNTW = AW + 1;
    localparam int RW   = $clog2(ROW_CAP + 1);
    localparam int CLW  = $clog2(COL_CAP + 1);
    localparam int CW   = $clog2(COL_CAP + TAB_WIDTH);
    localparam int PCW  = $clog2(MAX_PARAMS + 1);
    localparam int PIW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int RECIP_SH = 16;
    localparam int RECIP    = (1 << RECIP_SH) / TAB_WIDTH + 1;

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_READ  = 10'b0000000100,
        S_TAB   = 10'b0000001000,
        S_PRINT = 10'b0000010000,
        S_WRAP  = 10'b0000100000,
        S_COPY  = 10'b0001000000,
        S_FILL  = 10'b0010000000,
        S_PARAM = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]      rows_cfg_reg, rows_cfg_next;
    logic [7:0]      cols_cfg_reg, cols_cfg_next;
    logic [3:0]      dfg_reg, dfg_next;
    logic [3:0]      dbg_reg, dbg_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [3:0]      fg_reg, fg_next;
    logic [3:0]      bg_reg, bg_next;
    logic            bold_reg, bold_next;
    logic [7:0]      accum_reg, accum_next;
    logic [PCW-1:0]  pcount_reg, pcount_next;
    logic [7:0]      plist_reg [MAX_PARAMS];
    logic            plist_we;
    logic [PCW-1:0]  pidx_reg, pidx_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] end_reg, end_next;
    logic [CNTW-1:0] area_reg, copy_reg;
    logic [CW-1:0]   q_reg, q_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic            pv_reg, pv_next;
    logic [AW-1:0]   paddr_reg, paddr_next;
    cmd_t            cmd_reg, cmd_next;
    logic [15:0]     cell_reg, cell_next;
    logic            seq_reg, seq_next;

    logic            out_valid_reg, out_valid_next;
    logic [15:0]     out_cell_reg, out_cell_next;
    logic [6:0]      out_col_reg, out_col_next;
    logic [5:0]      out_row_reg, out_row_next;
    logic            out_esc_reg, out_esc_next;

    logic [15:0]     mem [STORE_SIZE];
    logic [15:0]     rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [15:0]     mem_wd;

    logic [RW-1:0]   eff_rows, new_rows;
    logic [CLW-1:0]  eff_cols, new_cols;
    logic [15:0]     blank;
    logic [7:0]      sgr_code;
    logic [CW-1:0]   wcol;
    logic [RW-1:0]   wrow;
    logic [8:0]      accum_wide;

    function automatic logic [RW-1:0] fit_rows(input logic [6:0] v);
        if (v == '0)
            return RW'(1);
        if (32'(v) > ROW_CAP)
            return RW'(ROW_CAP);
        return RW'(v);
    endfunction

    function automatic logic [CLW-1:0] fit_cols(input logic [7:0] v);
        if (v == '0)
            return CLW'(1);
        if (32'(v) > COL_CAP)
            return CLW'(COL_CAP);
        return CLW'(v);
    endfunction

    assign eff_rows  = fit_rows(rows_cfg_reg);
    assign eff_cols  = fit_cols(cols_cfg_reg);
    assign blank     = {bg_reg, fg_reg, CH_BLANK};
    assign init_busy = (state_reg == S_INIT);
    assign sgr_code  = plist_reg[pidx_reg[PIW-1:0]];

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.cell_value    = out_cell_reg;
    assign out_ch.cursor_col    = out_col_reg;
    assign out_ch.cursor_row    = out_row_reg;
    assign out_ch.escape_active = out_esc_reg;

    always_comb
    begin
        state_next    = state_reg;
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        dfg_next      = dfg_reg;
        dbg_next      = dbg_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        bold_next     = bold_reg;
        accum_next    = accum_reg;
        pcount_next   = pcount_reg;
        plist_we      = 1'b0;
        pidx_next     = pidx_reg;
        cnt_next      = cnt_reg;
        end_next      = end_reg;
        q_next        = q_reg;
        addr_next     = addr_reg;
        pv_next       = 1'b0;
        paddr_next    = paddr_reg;
        cmd_next      = cmd_reg;
        cell_next     = cell_reg;
        seq_next      = seq_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = blank;
        mem_ra        = '0;
        wcol          = col_reg;
        wrow          = row_reg;
        accum_wide    = '0;

        out_valid_next = out_valid_reg && !out_ch.ready;
        out_cell_next  = out_cell_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_esc_next   = out_esc_reg;

        // Drain the scroll copy pipeline
        if (pv_reg)
        begin
            mem_we = 1'b1;
            mem_wa = paddr_reg;
            mem_wd = rdata_reg;
        end

        unique case (state_reg)
            S_INIT:
            begin
                mem_we   = 1'b1;
                mem_wa   = AW'(cnt_reg);
                mem_wd   = RESET_CELL;
                cnt_next = CNTW'(cnt_reg + 1'b1);
                if (32'(cnt_reg) == STORE_SIZE - 1)
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_data;
                    seq_next  = q_data.seq;
                    cell_next = '0;
                    mem_ra    = AW'(q_data.index);
                    case (q_data.op)
                        OP_READ:  state_next = S_READ;
                        OP_BS:
                        begin
                            if (col_reg != '0)
                                col_next = CW'(col_reg - 1'b1);
                            state_next = S_WRAP;
                        end
                        OP_TAB:
                        begin
                            q_next     = CW'((32'(col_reg) * RECIP) >> RECIP_SH);
                            state_next = S_TAB;
                        end
                        OP_CR:
                        begin
                            col_next   = '0;
                            state_next = S_WRAP;
                        end
                        OP_LF:
                        begin
                            col_next   = '0;
                            row_next   = RW'(row_reg + 1'b1);
                            state_next = S_WRAP;
                        end
                        OP_ESC:   state_next = S_DONE;
                        OP_FF:
                        begin
                            cnt_next   = '0;
                            end_next   = area_reg;
                            col_next   = '0;
                            row_next   = '0;
                            state_next = S_FILL;
                        end
                        OP_PRINT:
                        begin
                            addr_next  = AW'(32'(row_reg) * 32'(eff_cols) + 32'(col_reg));
                            state_next = S_PRINT;
                        end
                        OP_NOP:   state_next = S_WRAP;
                        OP_DIGIT:
                        begin
                            accum_wide = 9'(12'(accum_reg) * 12'd10 +
                                         12'(q_data.code - CH_ZERO));
                            if ((12'(accum_reg) * 12'd10 + 12'(q_data.code - CH_ZERO))
                                > 12'd255)
                                accum_next = 8'hFF;
                            else
                                accum_next = accum_wide[7:0];
                            state_next = S_DONE;
                        end
                        OP_SEMI, OP_SGR:
                        begin
                            // Push the accumulated number; drop it when full
                            if (32'(pcount_reg) < MAX_PARAMS)
                            begin
                                plist_we    = 1'b1;
                                pcount_next = PCW'(pcount_reg + 1'b1);
                            end
                            accum_next = '0;
                            pidx_next  = '0;
                            state_next = (q_data.op == OP_SGR) ? S_PARAM : S_DONE;
                        end
                        OP_ABORT:
                        begin
                            accum_next  = '0;
                            pcount_next = '0;
                            state_next  = S_DONE;
                        end
                        default:  state_next = S_DONE;
                    endcase
                end
            end

            S_READ:
            begin
                cell_next  = (32'(cmd_reg.index) < STORE_SIZE) ? rdata_reg : '0;
                state_next = S_DONE;
            end

            S_TAB:
            begin
                col_next   = CW'((32'(q_reg) + 1) * TAB_WIDTH);
                state_next = S_WRAP;
            end

            S_PRINT:
            begin
                mem_we     = 1'b1;
                mem_wa     = addr_reg;
                mem_wd     = {bg_reg, fg_reg, cmd_reg.code};
                col_next   = CW'(col_reg + 1'b1);
                state_next = S_WRAP;
            end

            S_WRAP:
            begin
                if (32'(col_reg) >= 32'(eff_cols))
                begin
                    wcol = '0;
                    wrow = RW'(row_reg + 1'b1);
                end
                col_next = wcol;
                row_next = wrow;
                if (32'(wrow) >= 32'(eff_rows))
                begin
                    row_next   = RW'(eff_rows - 1'b1);
                    cnt_next   = '0;
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_COPY:
            begin
                // Move each row up: read one row below, write it in the next cycle
                if (cnt_reg < copy_reg)
                begin
                    mem_ra     = AW'(32'(cnt_reg) + 32'(eff_cols));
                    pv_next    = 1'b1;
                    paddr_next = AW'(cnt_reg);
                    cnt_next   = CNTW'(cnt_reg + 1'b1);
                end
                else if (!pv_reg)
                begin
                    cnt_next   = copy_reg;
                    end_next   = area_reg;
                    state_next = S_FILL;
                end
            end

            S_FILL:
            begin
                mem_we   = 1'b1;
                mem_wa   = AW'(cnt_reg);
                mem_wd   = blank;
                cnt_next = CNTW'(cnt_reg + 1'b1);
                if (CNTW'(cnt_reg + 1'b1) == end_reg)
                    state_next = S_DONE;
            end

            S_PARAM:
            begin
                unique case (sgr_code) inside
                    SGR_RESET:
                    begin
                        fg_next   = dfg_reg;
                        bg_next   = dbg_reg;
                        bold_next = 1'b0;
                    end
                    SGR_BOLD:
                    begin
                        if (!bold_reg)
                            fg_next = fg_reg + BOLD_OFFSET;
                        bold_next = 1'b1;
                    end
                    [SGR_FG_LO:SGR_FG_HI]:
                        fg_next = {1'b0, ansi_to_vga(sgr_code[2:0] - SGR_FG_LO[2:0])}
                                  + (bold_reg ? BOLD_OFFSET : 4'd0);
                    SGR_FG_DEF:
                        fg_next = dfg_reg;
                    [SGR_BG_LO:SGR_BG_HI]:
                        bg_next = {1'b0, ansi_to_vga(sgr_code[2:0] - SGR_BG_LO[2:0])};
                    SGR_BG_DEF:
                        bg_next = dbg_reg;
                    default: ;
                endcase
                pidx_next = PCW'(pidx_reg + 1'b1);
                if (PCW'(pidx_reg + 1'b1) == pcount_reg)
                begin
                    accum_next  = '0;
                    pcount_next = '0;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = cell_reg;
                    out_col_next   = 7'(col_reg);
                    out_row_next   = 6'(row_reg);
                    out_esc_next   = seq_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // Register writes: user keeps to idle, unchecked; pull cursor inside
        new_rows = fit_rows(rows_cfg_reg);
        new_cols = fit_cols(cols_cfg_reg);
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS:
                begin
                    rows_cfg_next = cfg_data[6:0];
                    new_rows      = fit_rows(cfg_data[6:0]);
                end
                CFG_COLS:
                begin
                    cols_cfg_next = cfg_data;
                    new_cols      = fit_cols(cfg_data);
                end
                CFG_DFG: dfg_next = cfg_data[3:0];
                CFG_DBG: dbg_next = cfg_data[3:0];
                default: ;
            endcase
            if ((cfg_index == CFG_ROWS || cfg_index == CFG_COLS))
            begin
                if (32'(row_next) >= 32'(new_rows))
                    row_next = RW'(new_rows - 1'b1);
                if (32'(col_next) >= 32'(new_cols))
                    col_next = CW'(new_cols - 1'b1);
            end
        end
    end

    // Screen store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (plist_we)
            plist_reg[pcount_reg[PIW-1:0]] <= accum_reg;
        area_reg  <= CNTW'(32'(eff_rows) * 32'(eff_cols));
        copy_reg  <= CNTW'((32'(eff_rows) - 1) * 32'(eff_cols));
        q_reg     <= q_next;
        addr_reg  <= addr_next;
        paddr_reg <= paddr_next;
        cmd_reg   <= cmd_next;
        cell_reg  <= cell_next;
        end_reg   <= end_next;
        out_cell_reg <= out_cell_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_esc_reg  <= out_esc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rows_cfg_reg  <= RST_ROWS;
            cols_cfg_reg  <= RST_COLS;
            dfg_reg       <= RST_DFG;
            dbg_reg       <= RST_DBG;
            col_reg       <= '0;
            row_reg       <= '0;
            fg_reg        <= RST_DFG;
            bg_reg        <= RST_DBG;
            bold_reg      <= 1'b0;
            accum_reg     <= '0;
            pcount_reg    <= '0;
            pidx_reg      <= '0;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            seq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            dfg_reg       <= dfg_next;
            dbg_reg       <= dbg_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            bold_reg      <= bold_next;
            accum_reg     <= accum_next;
            pcount_reg    <= pcount_next;
            pidx_reg      <= pidx_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/text_mode_terminal_engine.sv
// Path from queue head to result: a printable byte goes through S_IDLE, S_PRINT, S_WRAP
//   and S_DONE; a cell read through S_READ; an SGR end handles each held parameter in S_PARAM.
// Form feed fills the whole area; a scroll copies rows up and blanks the last row, both
//   bound by the single write port of the screen store.
// Throughput: one item at a time in the back end; a two-entry queue keeps the input open.
// Reset: control state clears at once, then a sweep of every store cell blanks the store.
// ----------------------------------------------------------------------------
// text_mode_terminal_engine
// Text-mode terminal with ANSI colour parser, screen store and scroll.
// ----------------------------------------------------------------------------
module text_mode_terminal_engine #(
    parameter int ROW_CAP    = 64,
    parameter int COL_CAP    = 128,
    parameter int MAX_PARAMS = 8,
    parameter int TAB_WIDTH  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tmt_in_if.sink                        in_ch,
    tmt_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [tmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tmt_pkg::*;

    // Front end to queue
    cmd_t push_data;
    logic push;
    logic full;

    // Queue to back end
    cmd_t pop_data;
    logic pop;
    logic empty;

    // High during the store sweep after reset; hold the input closed
    logic init_busy;

    // Classify each transfer and track the escape state
    tmt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_full    (full),
        .init_busy (init_busy),
        .q_push    (push),
        .q_data    (push_data)
    );

    // Decouple acceptance from execution
    tmt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    // Carry out commands: cursor, colours, store writes, scroll, result register
    tmt_back #(
        .ROW_CAP    (ROW_CAP),
        .COL_CAP    (COL_CAP),
        .MAX_PARAMS (MAX_PARAMS),
        .TAB_WIDTH  (TAB_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .init_busy (init_busy),
        .out_ch    (out_ch)
    );

endmodule
